// ===== hw/rtl/kfpq_pkg.sv =====
// Shared widths, codes and types for the keyed frequency priority queue.
`timescale 1ns / 1ps

package kfpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int MODE_W      = 2;
  localparam int KEY_W       = 32;
  localparam int FREQ_W      = 24;
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 7;

  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // updates to a frequency below this evict the entry
  localparam logic [FREQ_W-1:0] FREQ_KEEP_MIN = 24'd2;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_REMOVE = 2'd1;
  localparam cell_op_t CELL_INSERT = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [FREQ_W-1:0] freq;
  } slot_t;

  typedef struct packed {
    cell_op_t          op;
    logic              behind;  // insert behind equal frequencies
    logic [KEY_W-1:0]  key;
    logic [FREQ_W-1:0] freq;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/kfpq_ifs.sv =====
// Valid/ready channel interfaces for queue commands and results.
`timescale 1ns / 1ps

interface kfpq_item_if;
  logic                         valid;
  logic                         ready;
  logic [kfpq_pkg::MODE_W-1:0]  mode;
  logic [kfpq_pkg::KEY_W-1:0]   entry_key;
  logic [kfpq_pkg::FREQ_W-1:0]  entry_freq;

  modport source (output valid, mode, entry_key, entry_freq, input ready);
  modport sink   (input valid, mode, entry_key, entry_freq, output ready);
endinterface

interface kfpq_result_if;
  logic                             valid;
  logic                             ready;
  logic [kfpq_pkg::STATUS_W-1:0]    status;
  logic [kfpq_pkg::KEY_W-1:0]       out_key;
  logic [kfpq_pkg::FREQ_W-1:0]      out_freq;
  logic [kfpq_pkg::OUT_COUNT_W-1:0] out_count;

  modport source (output valid, status, out_key, out_freq, out_count, input ready);
  modport sink   (input valid, status, out_key, out_freq, out_count, output ready);
endinterface

// ===== hw/rtl/keyed_frequency_priority_queue.sv =====
// Top level: command sequencer, result register and the cell chain.
`timescale 1ns / 1ps

// Keyed frequency priority queue: up to CAPACITY (key, frequency) entries kept
// in descending frequency order in a row of cells, one entry per cell.
// items channel: mode (enqueue, update, dequeue), entry_key, entry_freq.
// results channel: one item per command with status, out_key, out_freq and
// out_count (entries after the command).
// Every cell compares its key at acceptance; the status and new count are
// settled then. The chain then shifts one step per state: a removal closes
// the gap, an insert opens one. States from acceptance to a result:
//   done, when nothing moves (duplicate, full, not found, equal, empty),
//   remove or insert, then done, for enqueue, dequeue and eviction,
//   remove, insert, then done, for an update that moves the entry.
// The next item is taken in the cycle after the result is registered, so no
// item is taken while the last is still in the chain. The result sits in an
// output register; if the receiver stalls, the finished item waits there and
// the next command still runs through the chain, stopping only when its own
// result has to be loaded. Reset (rst, synchronous) empties the queue: all
// cells invalid, count zero, no result pending.
module keyed_frequency_priority_queue (
  input  logic          clk,
  input  logic          rst,
  kfpq_item_if.sink     items,
  kfpq_result_if.source results
);
  import kfpq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]          state;
  logic [CNT_W-1:0]    count;
  logic                ins_pend;
  logic                behind;
  logic [KEY_W-1:0]    cmd_key;
  logic [FREQ_W-1:0]   cmd_freq;
  logic [CAPACITY-1:0] rm_vec;

  logic [STATUS_W-1:0]    res_status;
  logic [KEY_W-1:0]       res_key;
  logic [FREQ_W-1:0]      res_freq;

  logic                   o_valid;
  logic [STATUS_W-1:0]    o_status;
  logic [KEY_W-1:0]       o_key;
  logic [FREQ_W-1:0]      o_freq;
  logic [OUT_COUNT_W-1:0] o_count;

  cell_cmd_t           cmd;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic [FREQ_W-1:0]   match_freq;
  slot_t               head;
  logic                accept;
  logic                found;
  logic [CAPACITY-1:0] pfx [IDX_W+1];

  logic [STATUS_W-1:0] d_status;
  logic [KEY_W-1:0]    d_key;
  logic [FREQ_W-1:0]   d_freq;
  logic [CNT_W-1:0]    d_count;
  logic                d_rm;
  logic                d_ins;
  logic                d_behind;
  logic [CAPACITY-1:0] d_rm_vec;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.behind = behind;
    cmd.key    = cmd_key;
    cmd.freq   = cmd_freq;
    if (state == S_REMOVE)      cmd.op = CELL_REMOVE;
    else if (state == S_INSERT) cmd.op = CELL_INSERT;
  end

  kfpq_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .probe      (items.entry_key),
    .rm_vec     (rm_vec),
    .match_vec  (match_vec),
    .valid_vec  (valid_vec),
    .match_freq (match_freq),
    .head       (head)
  );

  assign found = |match_vec;

  // ranks at and behind the matched entry close up on removal
  always_comb begin
    pfx[0] = match_vec;
    for (int lv = 0; lv < IDX_W; lv++) begin
      pfx[lv+1] = pfx[lv] | (pfx[lv] << (1 << lv));
    end
  end

  always_comb begin
    d_status = ST_OK;
    d_key    = '0;
    d_freq   = '0;
    d_count  = count;
    d_rm     = 1'b0;
    d_ins    = 1'b0;
    d_behind = 1'b0;
    d_rm_vec = pfx[IDX_W];
    case (items.mode)
      MODE_ENQ: begin
        d_key = items.entry_key;
        if (found) begin
          d_status = ST_EXISTS;
          d_freq   = match_freq;
        end else if (count == CNT_W'(CAPACITY)) begin
          d_status = ST_FULL;
          d_freq   = items.entry_freq;
        end else begin
          d_freq  = items.entry_freq;
          d_ins   = 1'b1;
          d_count = count + 1'b1;
        end
      end
      MODE_UPD: begin
        d_key = items.entry_key;
        if (!found) begin
          d_status = ST_NOTFOUND;
        end else if (items.entry_freq == match_freq) begin
          d_freq = match_freq;
        end else if (items.entry_freq < FREQ_KEEP_MIN) begin
          d_status = ST_EVICTED;
          d_freq   = match_freq;
          d_rm     = 1'b1;
          d_count  = count - 1'b1;
        end else begin
          d_freq   = items.entry_freq;
          d_rm     = 1'b1;
          d_ins    = 1'b1;
          d_behind = items.entry_freq > match_freq;
        end
      end
      MODE_DEQ: begin
        d_rm_vec = '1;
        if (count == '0) begin
          d_status = ST_EMPTY;
        end else begin
          d_key   = head.key;
          d_freq  = head.freq;
          d_rm    = 1'b1;
          d_count = count - 1'b1;
        end
      end
      default: d_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ins_pend <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state == S_DONE && (!o_valid || results.ready)) begin
        o_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count    <= d_count;
            ins_pend <= d_ins;
            if (d_rm)       state <= S_REMOVE;
            else if (d_ins) state <= S_INSERT;
            else            state <= S_DONE;
          end
        end
        S_REMOVE: begin
          state <= ins_pend ? S_INSERT : S_DONE;
        end
        S_INSERT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!o_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= d_status;
      res_key    <= d_key;
      res_freq   <= d_freq;
      behind     <= d_behind;
      rm_vec     <= d_rm_vec;
      cmd_key    <= items.entry_key;
      cmd_freq   <= items.entry_freq;
    end
    if (state == S_DONE && (!o_valid || results.ready)) begin
      o_status <= res_status;
      o_key    <= res_key;
      o_freq   <= res_freq;
      o_count  <= OUT_COUNT_W'(count);
    end
  end

  assign results.valid     = o_valid;
  assign results.status    = o_status;
  assign results.out_key   = o_key;
  assign results.out_freq  = o_freq;
  assign results.out_count = o_count;

  // stored keys stay unique through every shift
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("more than one cell matches the probe key");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // live cells form a prefix whose length is the count once the chain is settled
  assert property (@(posedge clk) disable iff (rst)
      state == S_IDLE |-> $countones(valid_vec) == int'(count))
    else $error("valid cells disagree with occupancy");

  assert property (@(posedge clk) disable iff (rst)
      state == S_IDLE |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("live cells are not packed at the head");

  assert property (@(posedge clk) disable iff (rst)
      accept && items.mode == MODE_ENQ && !found && count != CNT_W'(CAPACITY)
      |=> state == S_INSERT && count == $past(count) + 1'b1)
    else $error("enqueue did not start an insert");

endmodule

// ===== hw/rtl/kfpq_cell.sv =====
// One rank of the sorted queue: holds an entry, compares, shifts with neighbors.
`timescale 1ns / 1ps

module kfpq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  kfpq_pkg::cell_cmd_t         cmd,
  input  logic [kfpq_pkg::KEY_W-1:0]  probe,
  input  kfpq_pkg::slot_t             prev_slot,
  input  logic                        prev_stay,
  input  kfpq_pkg::slot_t             next_slot,
  input  logic                        rm_here,
  output kfpq_pkg::slot_t             slot,
  output logic                        stay,
  output logic                        match
);
  import kfpq_pkg::*;

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [FREQ_W-1:0] freq;
  slot_t             slot_next;

  assign slot  = '{valid: valid, key: key, freq: freq};
  assign match = valid && (key == probe);
  // entry keeps its rank on insert when it sorts ahead of the new one
  assign stay  = valid && (cmd.behind ? (freq >= cmd.freq) : (freq > cmd.freq));

  always_comb begin
    slot_next = slot;
    case (cmd.op)
      CELL_REMOVE: begin
        if (rm_here) slot_next = next_slot;
      end
      CELL_INSERT: begin
        if (!stay) begin
          if (prev_stay) slot_next = '{valid: 1'b1, key: cmd.key, freq: cmd.freq};
          else           slot_next = prev_slot;
        end
      end
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    key  <= slot_next.key;
    freq <= slot_next.freq;
  end

endmodule

// ===== hw/rtl/kfpq_chain.sv =====
// Row of queue cells with neighbor wiring, key match vector and matched-frequency select.
`timescale 1ns / 1ps

module kfpq_chain (
  input  logic                               clk,
  input  logic                               rst,
  input  kfpq_pkg::cell_cmd_t                cmd,
  input  logic [kfpq_pkg::KEY_W-1:0]         probe,
  input  logic [kfpq_pkg::CAPACITY-1:0]      rm_vec,
  output logic [kfpq_pkg::CAPACITY-1:0]      match_vec,
  output logic [kfpq_pkg::CAPACITY-1:0]      valid_vec,
  output logic [kfpq_pkg::FREQ_W-1:0]        match_freq,
  output kfpq_pkg::slot_t                    head
);
  import kfpq_pkg::*;

  slot_t               slots [CAPACITY];
  logic [CAPACITY-1:0] stays;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t prev_slot;
    slot_t next_slot;
    logic  prev_stay;

    if (i == 0) begin : g_first
      assign prev_slot = '0;
      assign prev_stay = 1'b1;
    end else begin : g_mid
      assign prev_slot = slots[i-1];
      assign prev_stay = stays[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end

    kfpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .probe     (probe),
      .prev_slot (prev_slot),
      .prev_stay (prev_stay),
      .next_slot (next_slot),
      .rm_here   (rm_vec[i]),
      .slot      (slots[i]),
      .stay      (stays[i]),
      .match     (match_vec[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  assign head = slots[0];

  // keys are unique, so at most one term is live
  always_comb begin
    match_freq = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_freq = match_freq | (slots[i].freq & {FREQ_W{match_vec[i]}});
    end
  end

endmodule
